FILE: hdl/apr_pkg.sv
// Shared constants for the aging page-replacement core.
package apr_pkg;

  // Default geometry
  localparam int VIRTUAL_PAGES_DEF = 512;
  localparam int FRAMES_DEF        = 256;
  localparam int AGE_BITS_DEF      = 8;

  // Fixed field widths of the word ports
  localparam int PAGE_W  = 9;
  localparam int FRAME_W = 8;

  // Operation codes
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_TICK   = 1'b1;

endpackage

FILE: hdl/apr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module apr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/apr_unit.sv
// Shared compare/subtract unit: page reduction steps and age minimum search.
module apr_unit #(
  parameter int W = 10
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         lt,
  output logic [W-1:0] diff
);

  assign lt   = (a < b);
  assign diff = a - b;

endmodule

FILE: hdl/aging_page_replacement_core.sv
// Aging page-replacement core. Each input word is either an access to a
// virtual page or an aging tick, and each produces exactly one result word.
// A hit sets the page's referenced bit; a miss loads the page into the lowest
// free frame or, when all frames are used, evicts the resident page with the
// smallest age (ties to the lowest frame). A tick shifts every page's age
// right and moves the referenced bit into the top age bit. Page numbers at or
// above VIRTUAL_PAGES are reduced by repeated subtraction of VIRTUAL_PAGES.
// Sequence: after reset a clearing pass zeroes the page and frame tables;
// in_ready stays low meanwhile. Then one word is worked at a time. A hit
// passes through the reduce, look and done states, with one more reduce
// step per subtraction of an out-of-range page. A miss with a free frame
// scans the frame table from frame 0 up to the lowest free frame. A miss
// with eviction runs a pipelined scan of every frame, the frame table
// feeding the page table and the shared comparator. A tick sweeps the
// page table with one page-table read and one write per page. A finished
// result sits in the output register, so the next word is taken while the
// previous result still waits for out_ready.
module aging_page_replacement_core #(
  parameter int VIRTUAL_PAGES = apr_pkg::VIRTUAL_PAGES_DEF,
  parameter int FRAMES        = apr_pkg::FRAMES_DEF,
  parameter int AGE_BITS      = apr_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [apr_pkg::PAGE_W-1:0]  in_page,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [apr_pkg::FRAME_W-1:0] out_frame,
  output logic                        out_evicted_valid,
  output logic [apr_pkg::PAGE_W-1:0]  out_evicted_page
);

  localparam int PAGE_W  = apr_pkg::PAGE_W;
  localparam int FRAME_W = apr_pkg::FRAME_W;

  // Index and counter widths
  localparam int PAW   = $clog2(VIRTUAL_PAGES);
  localparam int FAW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SCW   = $clog2(FRAMES + 1);
  localparam int CNTW  = $clog2(FRAMES + 1);
  localparam int TW    = $clog2(VIRTUAL_PAGES + 1);
  localparam int CLR_N = (VIRTUAL_PAGES > FRAMES) ? VIRTUAL_PAGES : FRAMES;
  localparam int CLR_W = $clog2(CLR_N + 1);

  // Shared unit width: holds a raw page, VIRTUAL_PAGES itself and an age
  localparam int UW0 = (PAGE_W + 1 > PAW + 1) ? PAGE_W + 1 : PAW + 1;
  localparam int UW  = (UW0 > AGE_BITS) ? UW0 : AGE_BITS;

  // Page table word: {resident, referenced, age, frame}
  localparam int PWW     = 2 + AGE_BITS + FAW;
  localparam int AGE_LO  = FAW;
  localparam int AGE_HI  = FAW + AGE_BITS - 1;
  localparam int REF_BIT = FAW + AGE_BITS;
  localparam int RES_BIT = FAW + AGE_BITS + 1;

  // Frame table word: {used, page}
  localparam int FWW = 1 + PAW;

  // Sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_REDUCE = 4'd2;
  localparam logic [3:0] S_LOOK   = 4'd3;
  localparam logic [3:0] S_FREE   = 4'd4;
  localparam logic [3:0] S_VICT   = 4'd5;
  localparam logic [3:0] S_EVICT  = 4'd6;
  localparam logic [3:0] S_LOAD   = 4'd7;
  localparam logic [3:0] S_TICK   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [CLR_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [PAGE_W-1:0] pg_r, pg_nxt;
  logic [PWW-1:0]    cur_word_r, cur_word_nxt;

  // Scan pipeline
  logic [SCW-1:0]    scan_idx_r, scan_idx_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic [FAW-1:0]    s1_fr_r, s1_fr_nxt;
  logic              s2_v_r, s2_v_nxt;
  logic [FAW-1:0]    s2_fr_r, s2_fr_nxt;
  logic [PAW-1:0]    s2_pg_r, s2_pg_nxt;
  logic [FAW-1:0]    best_fr_r, best_fr_nxt;
  logic [PAW-1:0]    best_pg_r, best_pg_nxt;
  logic [PWW-1:0]    best_word_r, best_word_nxt;

  // Tick sweep
  logic [TW-1:0]     tick_idx_r, tick_idx_nxt;
  logic [PAW-1:0]    tk1_idx_r, tk1_idx_nxt;

  // Pending result
  logic              res_hit_r, res_hit_nxt;
  logic [FAW-1:0]    res_fr_r, res_fr_nxt;
  logic              res_evv_r, res_evv_nxt;
  logic [PAW-1:0]    res_evp_r, res_evp_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_evv_r, out_evv_nxt;
  logic [PAGE_W-1:0]  out_evp_r, out_evp_nxt;

  // Memory ports
  logic           p_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [PWW-1:0] p_wdata, prd_data;
  logic           f_we;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [FWW-1:0] f_wdata, frd_data;

  // Shared unit
  logic [UW-1:0] u_a, u_b, u_diff;
  logic          u_lt;

  logic [PAW-1:0]      pg_addr;
  logic [AGE_BITS-1:0] prd_age, best_age, tick_age;
  logic                frd_used;
  logic [PAW-1:0]      frd_page;
  logic                take;

  assign pg_addr  = PAW'(pg_r);
  assign prd_age  = prd_data[AGE_HI:AGE_LO];
  assign best_age = best_word_r[AGE_HI:AGE_LO];
  assign frd_used = frd_data[FWW-1];
  assign frd_page = frd_data[PAW-1:0];
  // Shift the age right, fold the referenced bit in at the top
  assign tick_age = {prd_data[REF_BIT], prd_age[AGE_BITS-1:1]};

  apr_ram #(.WIDTH(PWW), .DEPTH(VIRTUAL_PAGES)) u_page_tbl (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (prd_data)
  );

  apr_ram #(.WIDTH(FWW), .DEPTH(FRAMES)) u_frame_tbl (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (frd_data)
  );

  apr_unit #(.W(UW)) u_unit (
    .a    (u_a),
    .b    (u_b),
    .lt   (u_lt),
    .diff (u_diff)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame         = out_frame_r;
  assign out_evicted_valid = out_evv_r;
  assign out_evicted_page  = out_evp_r;

  // Shared unit operands: page reduction, else age compare during victim scan
  always_comb begin
    if (state_r == S_VICT) begin
      u_a = UW'(prd_age);
      u_b = UW'(best_age);
    end else begin
      u_a = UW'(pg_r);
      u_b = UW'(VIRTUAL_PAGES);
    end
  end

  // First candidate or strictly younger age wins, so ties stay at the lowest frame
  assign take = (s2_fr_r == '0) || u_lt;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    cnt_nxt       = cnt_r;
    pg_nxt        = pg_r;
    cur_word_nxt  = cur_word_r;
    scan_idx_nxt  = scan_idx_r;
    s1_v_nxt      = 1'b0;
    s1_fr_nxt     = s1_fr_r;
    s2_v_nxt      = 1'b0;
    s2_fr_nxt     = s2_fr_r;
    s2_pg_nxt     = s2_pg_r;
    best_fr_nxt   = best_fr_r;
    best_pg_nxt   = best_pg_r;
    best_word_nxt = best_word_r;
    tick_idx_nxt  = tick_idx_r;
    tk1_idx_nxt   = tk1_idx_r;
    res_hit_nxt   = res_hit_r;
    res_fr_nxt    = res_fr_r;
    res_evv_nxt   = res_evv_r;
    res_evp_nxt   = res_evp_r;

    p_we    = 1'b0;
    p_waddr = pg_addr;
    p_wdata = '0;
    p_raddr = pg_addr;
    f_we    = 1'b0;
    f_waddr = res_fr_r;
    f_wdata = '0;
    f_raddr = FAW'(scan_idx_r);

    out_valid_nxt = out_valid_r && !out_ready;
    out_hit_nxt   = out_hit_r;
    out_frame_nxt = out_frame_r;
    out_evv_nxt   = out_evv_r;
    out_evp_nxt   = out_evp_r;

    unique case (state_r)
      S_CLEAR: begin
        // Zero both tables, one entry a cycle
        p_we    = (clr_idx_r < CLR_W'(VIRTUAL_PAGES));
        p_waddr = PAW'(clr_idx_r);
        f_we    = (clr_idx_r < CLR_W'(FRAMES));
        f_waddr = FAW'(clr_idx_r);
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == CLR_W'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          pg_nxt       = in_page;
          tick_idx_nxt = '0;
          if (in_operation == apr_pkg::OP_TICK) begin
            state_nxt = S_TICK;
          end else begin
            state_nxt = S_REDUCE;
          end
        end
      end

      S_REDUCE: begin
        // Subtract VIRTUAL_PAGES until in range; read the page entry once it is
        if (u_lt) begin
          state_nxt = S_LOOK;
        end else begin
          pg_nxt = PAGE_W'(u_diff);
        end
      end

      S_LOOK: begin
        scan_idx_nxt = '0;
        if (prd_data[RES_BIT]) begin
          // Hit: set referenced, report the page's frame
          p_we        = 1'b1;
          p_wdata     = prd_data;
          p_wdata[REF_BIT] = 1'b1;
          res_hit_nxt = 1'b1;
          res_fr_nxt  = prd_data[FAW-1:0];
          res_evv_nxt = 1'b0;
          res_evp_nxt = '0;
          state_nxt   = S_DONE;
        end else begin
          cur_word_nxt = prd_data;
          res_hit_nxt  = 1'b0;
          res_evv_nxt  = 1'b0;
          res_evp_nxt  = '0;
          if (cnt_r < CNTW'(FRAMES)) begin
            state_nxt = S_FREE;
          end else begin
            state_nxt = S_VICT;
          end
        end
      end

      S_FREE: begin
        // Issue one frame read a cycle, check the used bit in the next cycle
        if (scan_idx_r < SCW'(FRAMES)) begin
          s1_v_nxt     = 1'b1;
          s1_fr_nxt    = FAW'(scan_idx_r);
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (s1_v_r && !frd_used) begin
          res_fr_nxt = s1_fr_r;
          s1_v_nxt   = 1'b0;
          state_nxt  = S_LOAD;
        end
      end

      S_VICT: begin
        // Stage 0: frame read; stage 1: page read of its page; stage 2: compare age
        if (scan_idx_r < SCW'(FRAMES)) begin
          s1_v_nxt     = 1'b1;
          s1_fr_nxt    = FAW'(scan_idx_r);
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        p_raddr = frd_page;
        if (s1_v_r) begin
          s2_v_nxt  = 1'b1;
          s2_fr_nxt = s1_fr_r;
          s2_pg_nxt = frd_page;
        end
        if (s2_v_r) begin
          if (take) begin
            best_fr_nxt   = s2_fr_r;
            best_pg_nxt   = s2_pg_r;
            best_word_nxt = prd_data;
          end
          if (s2_fr_r == FAW'(FRAMES - 1)) begin
            state_nxt = S_EVICT;
          end
        end
      end

      S_EVICT: begin
        // Drop residency of the victim, keep its age and referenced bit
        p_we    = 1'b1;
        p_waddr = best_pg_r;
        p_wdata = best_word_r;
        p_wdata[RES_BIT] = 1'b0;
        res_fr_nxt  = best_fr_r;
        res_evv_nxt = 1'b1;
        res_evp_nxt = best_pg_r;
        state_nxt   = S_LOAD;
      end

      S_LOAD: begin
        p_we    = 1'b1;
        p_wdata = {1'b1, 1'b1, cur_word_r[AGE_HI:AGE_LO], res_fr_r};
        f_we    = 1'b1;
        f_waddr = res_fr_r;
        f_wdata = {1'b1, pg_addr};
        if (!res_evv_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_TICK: begin
        // Read page i while writing back the aged page i-1
        if (tick_idx_r < TW'(VIRTUAL_PAGES)) begin
          p_raddr      = PAW'(tick_idx_r);
          s1_v_nxt     = 1'b1;
          tk1_idx_nxt  = PAW'(tick_idx_r);
          tick_idx_nxt = tick_idx_r + 1'b1;
        end
        if (s1_v_r) begin
          p_we    = 1'b1;
          p_waddr = tk1_idx_r;
          p_wdata = {prd_data[RES_BIT], 1'b0, tick_age, prd_data[FAW-1:0]};
          if (tk1_idx_r == PAW'(VIRTUAL_PAGES - 1)) begin
            res_hit_nxt = 1'b0;
            res_fr_nxt  = '0;
            res_evv_nxt = 1'b0;
            res_evp_nxt = '0;
            state_nxt   = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_frame_nxt = FRAME_W'(res_fr_r);
          out_evv_nxt   = res_evv_r;
          out_evp_nxt   = PAGE_W'(res_evp_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      cnt_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cnt_r       <= cnt_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pg_r        <= pg_nxt;
    cur_word_r  <= cur_word_nxt;
    scan_idx_r  <= scan_idx_nxt;
    s1_fr_r     <= s1_fr_nxt;
    s2_fr_r     <= s2_fr_nxt;
    s2_pg_r     <= s2_pg_nxt;
    best_fr_r   <= best_fr_nxt;
    best_pg_r   <= best_pg_nxt;
    best_word_r <= best_word_nxt;
    tick_idx_r  <= tick_idx_nxt;
    tk1_idx_r   <= tk1_idx_nxt;
    res_hit_r   <= res_hit_nxt;
    res_fr_r    <= res_fr_nxt;
    res_evv_r   <= res_evv_nxt;
    res_evp_r   <= res_evp_nxt;
    out_hit_r   <= out_hit_nxt;
    out_frame_r <= out_frame_nxt;
    out_evv_r   <= out_evv_nxt;
    out_evp_r   <= out_evp_nxt;
  end

endmodule
